>>> rtl/core/fvcd_pkg.sv
// Shared types, constants and saturation helper for the 1D convection-diffusion
// coefficient unit. No dependencies.
package fvcd_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_IDX_W     = 3;

  localparam logic        MODE_RST  = 1'b1;
  localparam logic [31:0] BEAST_RST = 32'd0;
  localparam logic [15:0] COUNT_RST = 16'd25;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 3'd0,
    REG_DENSITY = 3'd1,
    REG_DCOND   = 3'd2,
    REG_BWEST   = 3'd3,
    REG_BEAST   = 3'd4,
    REG_COUNT   = 3'd5
  } reg_idx_e;

  // one classified cell word, as it travels front -> queue -> back
  typedef struct packed {
    logic signed [31:0] vel_west;
    logic signed [31:0] vel_east;
    logic signed [31:0] src_lin;
    logic signed [31:0] src_const;
    logic               first;
    logic               last;
  } item_t;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] density;
    logic signed [31:0] dcond;
    logic signed [31:0] bwest;
    logic signed [31:0] beast;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] coeff_west;
    logic signed [31:0] coeff_east;
    logic signed [31:0] coeff_centre;
    logic signed [31:0] src_lin;
    logic signed [31:0] src_const;
    logic               saturated;
    logic               last_cell;
  } result_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               clip;
  } sat_t;

  // clip a wide signed value to 32 bits
  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    r.clip = 1'b1;
    if (v > 64'sd2147483647) begin
      r.val = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r.val = 32'sh80000000;
    end else begin
      r.val  = v[31:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/fvcd_front.sv
// Front end: accepts cell words, tracks the cell index, tags first/last cells.
// Depends on fvcd_pkg.
module fvcd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                q_full_i,
  input  logic signed [31:0]  vel_west_i,
  input  logic signed [31:0]  vel_east_i,
  input  logic signed [31:0]  src_lin_in_i,
  input  logic signed [31:0]  src_const_in_i,
  input  logic [15:0]         cell_count_i,
  output logic                q_push_o,
  output fvcd_pkg::item_t     q_item_o
);
  import fvcd_pkg::*;

  logic [15:0] cell_index_q, cell_index_d;
  logic [15:0] cnt;
  logic        is_first, is_last;

  // zero count acts as a single cell; an index past the count closes the grid
  assign cnt      = (cell_count_i == 16'd0) ? 16'd1 : cell_count_i;
  assign is_first = (cell_index_q == 16'd0);
  assign is_last  = (cell_index_q >= cnt - 16'd1);

  assign q_push_o = push_i && !q_full_i;

  always_comb begin
    q_item_o.vel_west  = vel_west_i;
    q_item_o.vel_east  = vel_east_i;
    q_item_o.src_lin   = src_lin_in_i;
    q_item_o.src_const = src_const_in_i;
    q_item_o.first     = is_first;
    q_item_o.last      = is_last;
  end

  always_comb begin
    cell_index_d = cell_index_q;
    if (q_push_o) begin
      cell_index_d = is_last ? 16'd0 : cell_index_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_index_q <= 16'd0;
    end else begin
      cell_index_q <= cell_index_d;
    end
  end

endmodule

>>> rtl/core/fvcd_queue.sv
// Short FIFO of classified cell words between front and back.
// Depends on fvcd_pkg.
module fvcd_queue #(
  parameter int DEPTH = fvcd_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fvcd_pkg::item_t  item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output fvcd_pkg::item_t  item_o
);
  import fvcd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t              mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> rtl/core/fvcd_back.sv
// Back end: sequencer around one shared 32x32 multiplier computing fluxes,
// coefficients and boundary source terms; holds the result register. Uses fvcd_pkg.
module fvcd_back #(
  parameter int FRAC_BITS = fvcd_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fvcd_pkg::cfg_t     cfg_i,
  input  logic               q_empty_i,
  input  fvcd_pkg::item_t    q_item_i,
  output logic               q_pop_o,
  input  logic               out_pop_i,
  output logic               out_valid_o,
  output fvcd_pkg::result_t  res_o
);
  import fvcd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FW   = 3'd1;
  localparam logic [2:0] ST_FE   = 3'd2;
  localparam logic [2:0] ST_AE   = 3'd3;
  localparam logic [2:0] ST_PW   = 3'd4;
  localparam logic [2:0] ST_PE   = 3'd5;
  localparam logic [2:0] ST_SU   = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0]          state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                out_load;

  item_t               item_q;
  logic signed [63:0]  prod_q, mul_p;
  logic signed [31:0]  mul_a, mul_b;
  logic signed [31:0]  fw_q, fe_q, aw_q, ae_q, tw_q, te_q, pw_q, pe_q;
  logic signed [31:0]  sp_q, su_q, ap_q;
  logic signed [32:0]  awae_q, fd_q;
  logic                clip_q;
  result_t             res_q;

  sat_t                qres, aw_s, ae_s, tw_s, te_s, sp_s, su_s, ap_s;

  logic signed [33:0]  d34, db34, aw_c, ae_c, neg_fe;
  logic signed [33:0]  mag_fw, mag_fe;
  logic signed [35:0]  lim;
  logic                cen_w, cen_e;
  logic signed [34:0]  tw_c, te_c;

  // ---- shared multiplier and fixed-point rescale ----
  always_comb begin
    unique case (state_q)
      ST_IDLE: begin mul_a = cfg_i.density; mul_b = q_item_i.vel_west; end
      ST_FW:   begin mul_a = cfg_i.density; mul_b = item_q.vel_east;   end
      ST_AE:   begin mul_a = tw_q;          mul_b = cfg_i.bwest;       end
      ST_PW:   begin mul_a = te_q;          mul_b = cfg_i.beast;       end
      default: begin mul_a = '0;            mul_b = '0;                end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);
  assign qres  = sat32(prod_q >>> FRAC_BITS);

  // ---- coefficient and boundary-term logic ----
  assign d34    = 34'(cfg_i.dcond);
  assign db34   = d34 <<< 1;
  assign lim    = 36'(cfg_i.dcond) <<< 2;
  assign neg_fe = -34'(fe_q);
  assign mag_fw = fw_q[31] ? -34'(fw_q) : 34'(fw_q);
  assign mag_fe = fe_q[31] ? neg_fe : 34'(fe_q);
  assign cen_w  = !cfg_i.mode || (36'(mag_fw) < lim);
  assign cen_e  = !cfg_i.mode || (36'(mag_fe) < lim);

  always_comb begin
    aw_c = d34 + 34'(fw_q >>> 1);
    if (cfg_i.mode) begin
      if (34'(fw_q) > aw_c) aw_c = 34'(fw_q);
      if (aw_c < 34'sd0)    aw_c = 34'sd0;
    end
    ae_c = d34 - 34'(fe_q >>> 1);
    if (cfg_i.mode) begin
      if (neg_fe > ae_c)    ae_c = neg_fe;
      if (ae_c < 34'sd0)    ae_c = 34'sd0;
    end
  end

  // upwind: west adds max(Fw,0), east subtracts max(-Fe,0) = adds min(Fe,0)
  assign tw_c = 35'(db34) + (cen_w ? 35'(fw_q) : (fw_q[31] ? 35'sd0 : 35'(fw_q)));
  assign te_c = cen_e ? 35'(db34) - 35'(fe_q)
                      : 35'(db34) + (fe_q[31] ? 35'(fe_q) : 35'sd0);

  assign aw_s = sat32(64'(aw_c));
  assign ae_s = sat32(64'(ae_c));
  assign tw_s = sat32(64'(tw_c));
  assign te_s = sat32(64'(te_c));
  assign sp_s = sat32(64'(sp_q) - 64'(state_q == ST_PW ? tw_q : te_q));
  assign su_s = sat32(64'(su_q) + 64'(state_q == ST_PE ? pw_q : pe_q));
  assign ap_s = sat32(64'(awae_q) + 64'(fd_q) - 64'(sp_q));

  // ---- sequencer ----
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_pop_i);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_pop_i && out_valid_q) out_valid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: if (!q_empty_i) state_d = ST_FW;
      ST_FW:   state_d = ST_FE;
      ST_FE:   state_d = ST_AE;
      ST_AE:   state_d = ST_PW;
      ST_PW:   state_d = ST_PE;
      ST_PE:   state_d = ST_SU;
      ST_SU:   state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    case (state_q)
      ST_IDLE: begin
        item_q <= q_item_i;
        sp_q   <= q_item_i.src_lin;
        su_q   <= q_item_i.src_const;
        clip_q <= 1'b0;
      end
      ST_FW: begin
        fw_q   <= qres.val;
        clip_q <= clip_q | qres.clip;
      end
      ST_FE: begin
        fe_q   <= qres.val;
        aw_q   <= item_q.first ? 32'sd0 : aw_s.val;
        tw_q   <= tw_s.val;
        clip_q <= clip_q | qres.clip | (item_q.first ? tw_s.clip : aw_s.clip);
      end
      ST_AE: begin
        ae_q   <= item_q.last ? 32'sd0 : ae_s.val;
        te_q   <= te_s.val;
        clip_q <= clip_q | (item_q.last ? te_s.clip : ae_s.clip);
      end
      ST_PW: begin
        pw_q <= qres.val;
        if (item_q.first) begin
          sp_q   <= sp_s.val;
          clip_q <= clip_q | qres.clip | sp_s.clip;
        end
      end
      ST_PE: begin
        pe_q   <= qres.val;
        awae_q <= 33'(aw_q) + 33'(ae_q);
        fd_q   <= 33'(fe_q) - 33'(fw_q);
        if (item_q.first) su_q <= su_s.val;
        if (item_q.last)  sp_q <= sp_s.val;
        clip_q <= clip_q | (item_q.first & su_s.clip)
                         | (item_q.last & (qres.clip | sp_s.clip));
      end
      ST_SU: begin
        if (item_q.last) su_q <= su_s.val;
        ap_q   <= ap_s.val;
        clip_q <= clip_q | ap_s.clip | (item_q.last & su_s.clip);
      end
      default: begin
      end
    endcase
    if (out_load) begin
      res_q.coeff_west   <= aw_q;
      res_q.coeff_east   <= ae_q;
      res_q.coeff_centre <= ap_q;
      res_q.src_lin      <= sp_q;
      res_q.src_const    <= su_q;
      res_q.saturated    <= clip_q;
      res_q.last_cell    <= item_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/core/fv_convection_diffusion_coeffs_unit.sv
// Top level of the 1D convection-diffusion coefficient unit: config registers,
// front end, word queue and back end. Depends on fvcd_pkg, fvcd_front, fvcd_queue, fvcd_back.
//
//  channel   direction  handshake            payload
//  cell in   input      push / full          vel_west, vel_east, src_lin_in, src_const_in
//  result    output     empty / pop          coeffs, sources, saturated, last_cell
//  config    input      cfg_we_i (no wait)   cfg_idx_i, cfg_data_i
//
// In the back end, each cell word is handled one at a time: the sequencer walks four
// products (two fluxes, two boundary products) through the single shared
// multiplier, one register stage after each, plus the add/saturate steps.
// The front accepts words into a 2-deep queue while the back is busy, and the
// back finishes into a one-word result register, so a stalled pop only halts
// the back once that register is occupied. Reset clears the cell index, the
// queue and all control; config registers go to their documented defaults.
module fv_convection_diffusion_coeffs_unit #(
  parameter int FRAC_BITS = fvcd_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic signed [31:0]             vel_west_i,
  input  logic signed [31:0]             vel_east_i,
  input  logic signed [31:0]             src_lin_in_i,
  input  logic signed [31:0]             src_const_in_i,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [31:0]             coeff_west_o,
  output logic signed [31:0]             coeff_east_o,
  output logic signed [31:0]             coeff_centre_o,
  output logic signed [31:0]             src_lin_out_o,
  output logic signed [31:0]             src_const_out_o,
  output logic                           saturated_o,
  output logic                           last_cell_o,
  input  logic                           cfg_we_i,
  input  logic [fvcd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i
);
  import fvcd_pkg::*;

  // 1.0 and 2.5 in the chosen fixed-point format
  localparam logic [31:0] DENS_RST  = 32'(1 << FRAC_BITS);
  localparam logic [31:0] DCOND_RST = 32'(5 << (FRAC_BITS - 1));

  cfg_t        cfg_q;
  logic [15:0] cell_count_q;

  logic        q_push, q_full, q_pop, q_empty;
  item_t       front_item, head_item;
  logic        out_valid;
  result_t     res;

  // ---- configuration registers; unknown indexes are dropped ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode    <= MODE_RST;
      cfg_q.density <= DENS_RST;
      cfg_q.dcond   <= DCOND_RST;
      cfg_q.bwest   <= DENS_RST;
      cfg_q.beast   <= BEAST_RST;
      cell_count_q  <= COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:    cfg_q.mode    <= cfg_data_i[0];
        REG_DENSITY: cfg_q.density <= cfg_data_i;
        REG_DCOND:   cfg_q.dcond   <= cfg_data_i;
        REG_BWEST:   cfg_q.bwest   <= cfg_data_i;
        REG_BEAST:   cfg_q.beast   <= cfg_data_i;
        REG_COUNT:   cell_count_q  <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // ---- front: accept and tag first/last ----
  fvcd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .q_full_i       (q_full),
    .vel_west_i     (vel_west_i),
    .vel_east_i     (vel_east_i),
    .src_lin_in_i   (src_lin_in_i),
    .src_const_in_i (src_const_in_i),
    .cell_count_i   (cell_count_q),
    .q_push_o       (q_push),
    .q_item_o       (front_item)
  );

  assign full = q_full;

  // ---- decoupling queue ----
  fvcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (head_item)
  );

  // ---- back: arithmetic sequencer and result register ----
  fvcd_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_item_i    (head_item),
    .q_pop_o     (q_pop),
    .out_pop_i   (pop),
    .out_valid_o (out_valid),
    .res_o       (res)
  );

  assign empty           = !out_valid;
  assign coeff_west_o    = res.coeff_west;
  assign coeff_east_o    = res.coeff_east;
  assign coeff_centre_o  = res.coeff_centre;
  assign src_lin_out_o   = res.src_lin;
  assign src_const_out_o = res.src_const;
  assign saturated_o     = res.saturated;
  assign last_cell_o     = res.last_cell;

`ifndef SYNTH
  // front never writes a word into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full)) else $error("queue written while full");

  // back only takes a word the queue really holds
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty)) else $error("queue read while empty");

  // a word taken by the back cannot reach the result port the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && empty) |=> empty) else $error("result appeared too early");
`endif

endmodule

>>> bench/fvcd_coeffs_checker.sv
`timescale 1ns / 1ps
// Checker for the 1D convection-diffusion coefficient unit: mirrors the config
// registers and cell index, predicts each result word and compares it on pop.
// Depends on fvcd_pkg.
module fvcd_coeffs_checker #(
  parameter int FRAC_BITS = fvcd_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  input  logic                           full,
  input  logic signed [31:0]             vel_west_i,
  input  logic signed [31:0]             vel_east_i,
  input  logic signed [31:0]             src_lin_in_i,
  input  logic signed [31:0]             src_const_in_i,
  input  logic                           empty,
  input  logic                           pop,
  input  logic signed [31:0]             coeff_west_o,
  input  logic signed [31:0]             coeff_east_o,
  input  logic signed [31:0]             coeff_centre_o,
  input  logic signed [31:0]             src_lin_out_o,
  input  logic signed [31:0]             src_const_out_o,
  input  logic                           saturated_o,
  input  logic                           last_cell_o,
  input  logic                           cfg_we_i,
  input  logic [fvcd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  output int                             mismatches_o,
  output int                             outstanding_o,
  output int                             checked_o
);
  import fvcd_pkg::*;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam logic signed [31:0] DENSITY_RST = 32'sh0001_0000;  // 1.0
  localparam logic signed [31:0] DCOND_RST   = 32'sh0002_8000;  // 2.5
  localparam logic signed [31:0] BWEST_RST   = 32'sh0001_0000;  // 1.0

  logic               mode_q;
  logic signed [31:0] density_q, dcond_q, bwest_q, beast_q;
  logic [15:0]        count_q, index_q;
  bit                 clip_hit;
  result_t            coeff_words_q[$];

  initial begin
    mismatches_o  = 0;
    outstanding_o = 0;
    checked_o     = 0;
  end

  function automatic longint clamp_q(input longint v);
    if (v > Q_MAX) begin
      clip_hit = 1'b1;
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      clip_hit = 1'b1;
      return Q_MIN;
    end
    return v;
  endfunction

  // exact product, floor shift, clip
  function automatic longint mul_q(input longint a, input longint b);
    return clamp_q((a * b) >>> FRAC_BITS);
  endfunction

  function automatic longint max_q(input longint a, input longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic longint abs_q(input longint a);
    return (a < 0) ? -a : a;
  endfunction

  function automatic result_t predict_coeffs(input longint vw, input longint ve,
                                              input longint lin, input longint cst);
    result_t r;
    longint d, db, fw, fe, sp, su, aw, ae, t, ap, cnt;
    bit first, last, hyb;
    clip_hit = 1'b0;
    d   = dcond_q;
    db  = 2 * d;
    fw  = mul_q(density_q, vw);
    fe  = mul_q(density_q, ve);
    sp  = lin;
    su  = cst;
    cnt = (count_q == 16'd0) ? 1 : longint'(count_q);
    first = (index_q == 16'd0);
    last  = (longint'(index_q) >= cnt - 1);
    hyb   = mode_q;
    aw = 0;
    ae = 0;
    if (!first) begin
      aw = d + (fw >>> 1);
      if (hyb) aw = max_q(max_q(fw, aw), 0);
      aw = clamp_q(aw);
    end else begin
      if (!hyb || abs_q(fw) < 2 * db) t = db + fw;
      else t = db + max_q(fw, 0);
      t  = clamp_q(t);
      sp = clamp_q(sp - t);
      su = clamp_q(su + mul_q(t, bwest_q));
    end
    if (!last) begin
      ae = d - (fe >>> 1);
      if (hyb) ae = max_q(max_q(-fe, ae), 0);
      ae = clamp_q(ae);
    end else begin
      if (!hyb || abs_q(fe) < 2 * db) t = db - fe;
      else t = db - max_q(-fe, 0);
      t  = clamp_q(t);
      sp = clamp_q(sp - t);
      su = clamp_q(su + mul_q(t, beast_q));
    end
    ap = clamp_q(aw + ae + (fe - fw) - sp);
    r.coeff_west   = aw[31:0];
    r.coeff_east   = ae[31:0];
    r.coeff_centre = ap[31:0];
    r.src_lin      = sp[31:0];
    r.src_const    = su[31:0];
    r.saturated    = clip_hit;
    r.last_cell    = last;
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches_o++;
    $display("mismatch at word %0d: %s", checked_o, msg);
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) note_mismatch($sformatf("%s expected %h got %h", field, want, got));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      mode_q    = MODE_RST;
      density_q = DENSITY_RST;
      dcond_q   = DCOND_RST;
      bwest_q   = BWEST_RST;
      beast_q   = BEAST_RST;
      count_q   = COUNT_RST;
      index_q   = 16'd0;
      coeff_words_q.delete();
      outstanding_o = 0;
    end else begin
      if (pop && !empty) begin
        if (coeff_words_q.size() == 0) begin
          note_mismatch("result word with nothing outstanding");
        end else begin
          want = coeff_words_q.pop_front();
          check_field("coeff_west", want.coeff_west, coeff_west_o);
          check_field("coeff_east", want.coeff_east, coeff_east_o);
          check_field("coeff_centre", want.coeff_centre, coeff_centre_o);
          check_field("src_lin_out", want.src_lin, src_lin_out_o);
          check_field("src_const_out", want.src_const, src_const_out_o);
          check_field("saturated", want.saturated, saturated_o);
          check_field("last_cell", want.last_cell, last_cell_o);
          checked_o++;
        end
      end
      if (push && !full) begin
        want = predict_coeffs(vel_west_i, vel_east_i, src_lin_in_i, src_const_in_i);
        coeff_words_q.push_back(want);
        index_q = want.last_cell ? 16'd0 : index_q + 16'd1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:    mode_q    = cfg_data_i[0];
          REG_DENSITY: density_q = cfg_data_i;
          REG_DCOND:   dcond_q   = cfg_data_i;
          REG_BWEST:   bwest_q   = cfg_data_i;
          REG_BEAST:   beast_q   = cfg_data_i;
          REG_COUNT:   count_q   = cfg_data_i[15:0];
          default: ;
        endcase
      end
      outstanding_o = coeff_words_q.size();
    end
  end

endmodule

>>> bench/fv_convection_diffusion_coeffs_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the 1D convection-diffusion coefficient unit: drives cell
// words and register writes, and gives the verdict. Depends on fvcd_pkg, the unit
// and fvcd_coeffs_checker.
module fv_convection_diffusion_coeffs_unit_tb;
  import fvcd_pkg::*;

  // Q16.16 helpers for the directed part
  localparam logic [31:0] ONE     = 32'h0001_0000;
  localparam logic [31:0] Q_TOP   = 32'h7fff_ffff;
  localparam logic [31:0] Q_FLOOR = 32'h8000_0000;

  // register indexes that decode to nothing; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_WORDS   = 120;
  localparam int VEL_SPAN      = 12 * 65536;  // around the hybrid threshold of typical D
  localparam int SRC_SPAN      = 16 * 65536;
  localparam int SETTLE_CYCLES = 24;          // back end takes one word at a time, 2-deep queue
  localparam int DRAIN_CYCLES  = 64;
  localparam int CYCLE_LIMIT   = 400000;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 push           = 1'b0;
  logic                 full;
  logic signed [31:0]   vel_west_i     = '0;
  logic signed [31:0]   vel_east_i     = '0;
  logic signed [31:0]   src_lin_in_i   = '0;
  logic signed [31:0]   src_const_in_i = '0;
  logic                 empty;
  logic                 pop            = 1'b0;
  logic signed [31:0]   coeff_west_o, coeff_east_o, coeff_centre_o;
  logic signed [31:0]   src_lin_out_o, src_const_out_o;
  logic                 saturated_o, last_cell_o;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i      = '0;
  logic [31:0]          cfg_data_i     = '0;

  int mismatches, outstanding, checked;
  int tx_idle_pct  = 14;
  int rx_stall_pct = 14;
  int words_sent   = 0;
  int settings     = 1;   // reset values count as the first setting
  int cycle_count  = 0;

  fv_convection_diffusion_coeffs_unit dut (
    .clk_i, .rst_ni, .push, .full,
    .vel_west_i, .vel_east_i, .src_lin_in_i, .src_const_in_i,
    .empty, .pop,
    .coeff_west_o, .coeff_east_o, .coeff_centre_o,
    .src_lin_out_o, .src_const_out_o, .saturated_o, .last_cell_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  fvcd_coeffs_checker coeff_check (
    .mismatches_o (mismatches),
    .outstanding_o(outstanding),
    .checked_o    (checked),
    .*
  );

  always #10 clk_i = ~clk_i;

  // watchdog: a correct run finishes far below this
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count, outstanding);
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: pops at random; one assignment per falling edge.
  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= rx_stall_pct);
  end

  // Q16.16 value: mostly moderate, sometimes the extremes or any 32-bit pattern.
  function automatic logic [31:0] rand_q(input int unsigned span);
    case ($urandom_range(15))
      0:       return Q_TOP;
      1:       return Q_FLOOR;
      2, 3, 4: return $urandom();
      default: return $urandom_range(2 * span) - span;
    endcase
  endfunction

  // One cell word. Idle cycles carry junk on the payload to show it is ignored.
  // Called at a falling edge, returns at a falling edge with push still high,
  // so back-to-back words keep push up without a glitch.
  task automatic send_word(input logic [31:0] vw, input logic [31:0] ve,
                           input logic [31:0] lin, input logic [31:0] cst);
    while ($urandom_range(99) < tx_idle_pct) begin
      push           <= 1'b0;
      vel_west_i     <= $urandom();
      vel_east_i     <= $urandom();
      src_lin_in_i   <= $urandom();
      src_const_in_i <= $urandom();
      @(negedge clk_i);
    end
    push           <= 1'b1;
    vel_west_i     <= vw;
    vel_east_i     <= ve;
    src_lin_in_i   <= lin;
    src_const_in_i <= cst;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  // Plain write port, no wait; a gap cycle keeps we from toggling twice in a step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  // Stop sending, wait for every outstanding word, then let the back end go quiet.
  task automatic settle();
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [31:0] mode_w, dens_w, dcond_w, bw_w, be_w, count_w;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // ---- directed part ----
    // Reset setting: hybrid, density 1.0, D 2.5, west 1.0, east 0, 25 cells.
    send_word(ONE, ONE, '0, '0);                   // first cell, below the hybrid limit
    send_word(Q_TOP, Q_FLOOR, Q_TOP, Q_FLOOR);     // interior, field extremes
    send_word(Q_FLOOR, Q_TOP, Q_FLOOR, Q_TOP);
    send_word('0, '0, '0, '0);
    send_word('1, '1, '1, '1);                     // -1 ulp everywhere
    settle();
    // Count drops under the running index: the next word is taken as the last.
    write_reg(REG_COUNT, 32'd3);
    settings++;
    send_word(20 * ONE, -20 * ONE, ONE, ONE);
    send_word(-20 * ONE, 20 * ONE, '0, '0);        // first cell, upwind west term
    send_word(3 * ONE, -3 * ONE, '0, '0);
    send_word(20 * ONE, 20 * ONE, '0, '0);         // last cell, upwind east term
    settle();
    // Central scheme on a single-cell grid, both boundaries, saturating.
    write_reg(REG_MODE, 32'd0);
    write_reg(REG_COUNT, 32'd1);
    write_reg(REG_BWEST, Q_TOP);
    write_reg(REG_DENSITY, Q_TOP);
    settings++;
    send_word(Q_TOP, Q_FLOOR, Q_FLOOR, Q_TOP);
    send_word(ONE, -ONE, '0, '0);
    settle();
    // Zero count behaves like one cell.
    write_reg(REG_COUNT, 32'd0);
    settings++;
    send_word(5 * ONE, 5 * ONE, ONE, -ONE);
    send_word(Q_FLOOR, Q_FLOOR, '0, '0);
    settle();
    // Hybrid with negative conductance: boundary terms fall back to upwind.
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_DENSITY, ONE);
    write_reg(REG_BWEST, ONE);
    write_reg(REG_BEAST, -2 * ONE);
    write_reg(REG_DCOND, -ONE);
    write_reg(REG_COUNT, 32'd2);
    settings++;
    send_word(ONE, ONE, '0, '0);
    send_word(-ONE, -ONE, '0, '0);
    settle();
    // Zero conductance, same test.
    write_reg(REG_DCOND, '0);
    settings++;
    send_word(ONE, -ONE, ONE, ONE);
    send_word(-ONE, ONE, -ONE, -ONE);
    settle();
    // Writes to undecoded indexes change nothing.
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '0);
    send_word(2 * ONE, ONE, '0, '0);
    send_word(-2 * ONE, ONE, ONE, '0);

    // ---- random part ----
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 76; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 76; end
        default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
      endcase
      if (p == 0) begin
        // all positive extremes, longest grid
        mode_w = 32'd1; dens_w = Q_TOP; dcond_w = Q_TOP;
        bw_w = Q_TOP; be_w = Q_TOP; count_w = 32'h0000_ffff;
      end else if (p == 1) begin
        mode_w = 32'd0; dens_w = Q_FLOOR; dcond_w = Q_FLOOR;
        bw_w = Q_FLOOR; be_w = Q_FLOOR; count_w = 32'd1;
      end else begin
        // unused upper bits of mode and count get junk
        mode_w  = ($urandom() & 32'hffff_fffe) | $urandom_range(1);
        dens_w  = rand_q(3 * 65536);
        dcond_w = rand_q(4 * 65536);
        bw_w    = rand_q(4 * 65536);
        be_w    = rand_q(4 * 65536);
        case ($urandom_range(9))
          0:       count_w = 32'd0;
          1:       count_w = $urandom_range(65535);
          2, 3:    count_w = $urandom_range(40, 7);
          default: count_w = $urandom_range(6, 1);
        endcase
        count_w = ($urandom() & 32'hffff_0000) | count_w;
      end
      write_reg(REG_MODE, mode_w);
      write_reg(REG_DENSITY, dens_w);
      write_reg(REG_DCOND, dcond_w);
      write_reg(REG_BWEST, bw_w);
      write_reg(REG_BEAST, be_w);
      write_reg(REG_COUNT, count_w);
      if ($urandom_range(3) == 0) write_reg(REG_SPARE_B, $urandom());
      settings++;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // hold off mid-phase until the unit has handed back everything
        if (p == 2 && n == PHASE_WORDS / 2) settle();
        send_word(rand_q(VEL_SPAN), rand_q(VEL_SPAN), rand_q(SRC_SPAN), rand_q(SRC_SPAN));
      end
    end

    // ---- drain and verdict ----
    settle();
    rx_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("%0d cell words over %0d register settings, %0d result words checked",
             words_sent, settings, checked);
    $display("idle mixes: none, sender 76%%, receiver 76%%, both 14%%; %0d mismatches",
             mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
